// ===== hw/rtl/mata_pkg.sv =====
// ----------------------------------------------------------------------------
// mata_pkg
// Shared types and constants of the moving average threshold alarm.
// ----------------------------------------------------------------------------
package mata_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned WINDOW       = 5;
  localparam int unsigned SAMPLE_BITS  = 16;

  localparam int unsigned CH_W     = $clog2(NUM_CHANNELS);
  localparam int unsigned SLOT_W   = $clog2(WINDOW);
  localparam int unsigned ADDR_W   = $clog2(NUM_CHANNELS * WINDOW);
  localparam int unsigned SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned EVENT_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Divide by WINDOW through a reciprocal, exact for every SUM_W-bit sum
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned MULT_W    = DIV_SHIFT + 1;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  localparam int unsigned IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((SAMPLE_BITS + 2 + EVENT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ALARM_NORMAL    = 2'd0,
    ALARM_FIRST     = 2'd1,
    ALARM_SUSTAINED = 2'd2,
    ALARM_RECOVERED = 2'd3
  } alarm_e;

endpackage

// ===== hw/rtl/moving_average_threshold_alarm_top.sv =====
// ----------------------------------------------------------------------------
// moving_average_threshold_alarm_top
// Per-channel moving average with a persistence alarm on the window sum.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; window memory read and write share the
// accept cycle, running sum updates in stage 1, alarm and divide in stage 2.
// A stalled output holds the whole pipeline.
// Reset clears per-channel state and counters and sets all limits to 65535;
// the window memory is not cleared, a channel's first sample is tracked.
module moving_average_threshold_alarm_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mata_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // sample
  input  logic [mata_pkg::CH_W-1:0]       s_axis_tuser,   // channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // average, alarm_state, sustained_events, zero pad
  output logic [mata_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [mata_pkg::CH_W-1:0]       m_axis_tuser,   // out_channel
  input  logic                            cfg_we_i,
  input  logic [mata_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mata_pkg::LIMIT_W-1:0]    cfg_data_i
);
  import mata_pkg::*;

  logic en, accept;

  logic [LIMIT_W-1:0]     limit_q  [NUM_CHANNELS];
  logic [SLOT_W-1:0]      slot_q   [NUM_CHANNELS];
  logic                   primed_q [NUM_CHANNELS];
  logic                   filled_q [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] prime_q  [NUM_CHANNELS];
  logic [SUM_W-1:0]       sum_q    [NUM_CHANNELS];
  logic [1:0]             run_q    [NUM_CHANNELS];
  logic [EVENT_W-1:0]     events_q, events_d;

  logic [SAMPLE_BITS-1:0] win_mem [NUM_CHANNELS*WINDOW];
  logic [SAMPLE_BITS-1:0] mem_rdata_q;

  logic [CH_W-1:0]        in_ch;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic [SLOT_W-1:0]      in_slot, slot_nxt;
  logic [ADDR_W-1:0]      mem_addr;

  logic                   s1_vld_q, s1_first_q, s1_filled_q;
  logic [CH_W-1:0]        s1_ch_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q, s1_prime_q, s1_old;
  logic [SUM_W-1:0]       s1_sum_d;

  logic                   s2_vld_q;
  logic [CH_W-1:0]        s2_ch_q;
  logic [SUM_W-1:0]       s2_sum_q;

  logic [SUM_W-1:0]        lim_scaled;
  logic                    exceed;
  logic [1:0]              run_d;
  alarm_e                  state_d;
  logic [SUM_W+MULT_W-1:0] div_prod;
  logic [SAMPLE_BITS-1:0]  avg_d;

  logic                   m_vld_q;
  logic [CH_W-1:0]        m_ch_q;
  logic [SAMPLE_BITS-1:0] m_avg_q;
  alarm_e                 m_state_q;
  logic [EVENT_W-1:0]     m_events_q;

  assign en            = !m_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && en;
  assign s_axis_tready = en;

  // Stage 0: slot bookkeeping, window memory read-old / write-new
  assign in_ch    = s_axis_tuser;
  assign in_smp   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_slot  = slot_q[in_ch];
  assign slot_nxt = (in_slot == SLOT_W'(WINDOW - 1)) ? '0 : in_slot + SLOT_W'(1);
  assign mem_addr = ADDR_W'(in_ch) * ADDR_W'(WINDOW) + ADDR_W'(in_slot);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_mem[mem_addr] <= in_smp;
      mem_rdata_q       <= win_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        slot_q[i]   <= '0;
        primed_q[i] <= 1'b0;
        filled_q[i] <= 1'b0;
      end
    end else if (accept) begin
      slot_q[in_ch]   <= slot_nxt;
      primed_q[in_ch] <= 1'b1;
      if (primed_q[in_ch] && slot_nxt == '0) begin
        filled_q[in_ch] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!primed_q[in_ch]) begin
        prime_q[in_ch] <= in_smp;
      end
      s1_ch_q     <= in_ch;
      s1_smp_q    <= in_smp;
      s1_first_q  <= !primed_q[in_ch];
      s1_filled_q <= filled_q[in_ch];
      s1_prime_q  <= prime_q[in_ch];
    end
  end

  // Stage 1: running sum
  assign s1_old   = s1_filled_q ? mem_rdata_q : s1_prime_q;
  assign s1_sum_d = s1_first_q ? SUM_W'(s1_smp_q) * SUM_W'(WINDOW)
                               : sum_q[s1_ch_q] - SUM_W'(s1_old) + SUM_W'(s1_smp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
    end else if (en && s1_vld_q) begin
      sum_q[s1_ch_q] <= s1_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ch_q  <= s1_ch_q;
      s2_sum_q <= s1_sum_d;
    end
  end

  // Stage 2: threshold, persistence run, event count, average
  assign lim_scaled = SUM_W'(limit_q[s2_ch_q]) * SUM_W'(WINDOW);
  assign exceed     = s2_sum_q > lim_scaled;
  assign div_prod   = (SUM_W+MULT_W)'(s2_sum_q) * (SUM_W+MULT_W)'(DIV_MULT);
  assign avg_d      = div_prod[DIV_SHIFT +: SAMPLE_BITS];

  always_comb begin
    run_d    = run_q[s2_ch_q];
    events_d = events_q;
    state_d  = ALARM_NORMAL;
    if (exceed) begin
      if (run_q[s2_ch_q] < 2'd2) begin
        run_d = run_q[s2_ch_q] + 2'd1;
      end
      if (run_d == 2'd1) begin
        state_d = ALARM_FIRST;
      end else begin
        state_d  = ALARM_SUSTAINED;
        events_d = events_q + EVENT_W'(1);
      end
    end else begin
      state_d = (run_q[s2_ch_q] >= 2'd2) ? ALARM_RECOVERED : ALARM_NORMAL;
      run_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        run_q[i] <= '0;
      end
      events_q <= '0;
    end else if (en && s2_vld_q) begin
      run_q[s2_ch_q] <= run_d;
      events_q       <= events_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_ch_q     <= s2_ch_q;
      m_avg_q    <= avg_d;
      m_state_q  <= state_d;
      m_events_q <= events_d;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else if (en) begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      m_vld_q  <= s2_vld_q;
    end
  end

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        limit_q[i] <= LIMIT_RESET;
      end
    end else if (cfg_we_i) begin
      limit_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tuser  = m_ch_q;
  assign m_axis_tdata  = {
    (OUT_TDATA_W - SAMPLE_BITS - 2 - EVENT_W)'(0),
    m_events_q,
    m_state_q,
    m_avg_q
  };

endmodule

// ===== hw/rtl/mata_checker.sv =====
// ----------------------------------------------------------------------------
// mata_checker
// Port-level checks of the moving average threshold alarm.
// ----------------------------------------------------------------------------
module mata_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mata_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mata_pkg::*;

  logic               out_acc;
  logic [EVENT_W-1:0] events;
  logic [1:0]         state;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign events  = m_axis_tdata[SAMPLE_BITS+2 +: EVENT_W];
  assign state   = m_axis_tdata[SAMPLE_BITS +: 2];

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  a_events_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && $past(out_acc) |->
      events == $past(events) + EVENT_W'(state == ALARM_SUSTAINED))
    else $error("sustained event count out of step with alarm state");

  a_sustained_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && state == ALARM_SUSTAINED |-> events != '0)
    else $error("sustained alarm with zero event count");

endmodule

bind moving_average_threshold_alarm_top mata_checker u_mata_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the moving average threshold alarm. An in-bench
// filter model predicts average, alarm state and event count per sample
// request; the sender runs in bursts and the receiver stalls on its own
// pattern. Limits are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import mata_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned PHASE_ITEMS = 275;
  localparam int unsigned NUM_PHASES  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_CH0 = 2'd0,
    REG_LIMIT_CH1 = 2'd1,
    REG_LIMIT_CH2 = 2'd2,
    REG_LIMIT_CH3 = 2'd3
  } limit_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] smp;
  } sample_req_t;

  typedef struct packed {
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] avg;
    alarm_e                 state;
    logic [EVENT_W-1:0]     events;
  } alarm_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CH_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [CH_W-1:0]        m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [LIMIT_W-1:0]     cfg_data_i = '0;

  // filter model state
  logic [SAMPLE_BITS-1:0] win_data [NUM_CHANNELS][WINDOW];
  logic [SLOT_W-1:0]      win_slot [NUM_CHANNELS];
  logic [SUM_W-1:0]       win_sum [NUM_CHANNELS];
  logic                   win_primed [NUM_CHANNELS];
  logic [1:0]             exceed_len [NUM_CHANNELS];
  logic [EVENT_W-1:0]     event_count;
  logic [LIMIT_W-1:0]     ch_limit [NUM_CHANNELS];

  sample_req_t   sample_queue [$];
  alarm_result_t avg_expected [$];

  sample_req_t   drv_req;
  sample_req_t   mon_req;
  int            burst_left;
  int            gap_left;
  int            stall_mode;
  int            mode_left;
  alarm_result_t exp_res;
  alarm_result_t got_res;
  int            errors = 0;
  int unsigned   cycle_count = 0;

  moving_average_threshold_alarm_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_filter();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      win_slot[c]   = '0;
      win_sum[c]    = '0;
      win_primed[c] = 1'b0;
      exceed_len[c] = '0;
      ch_limit[c]   = LIMIT_RESET;
    end
    event_count = '0;
  endfunction

  function automatic alarm_result_t filter_sample(input sample_req_t req);
    alarm_result_t   res;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W:0]    bound;
    slot = win_slot[req.ch];
    if (!win_primed[req.ch]) begin
      for (int i = 0; i < WINDOW; i++) win_data[req.ch][i] = req.smp;
      win_sum[req.ch]    = SUM_W'(req.smp) * SUM_W'(WINDOW);
      win_primed[req.ch] = 1'b1;
    end else begin
      win_sum[req.ch] = win_sum[req.ch] - SUM_W'(win_data[req.ch][slot]) + SUM_W'(req.smp);
      win_data[req.ch][slot] = req.smp;
    end
    win_slot[req.ch] = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
    bound = (SUM_W + 1)'(ch_limit[req.ch]) * (SUM_W + 1)'(WINDOW);
    if ({1'b0, win_sum[req.ch]} > bound) begin
      if (exceed_len[req.ch] < 2'd2) exceed_len[req.ch] = exceed_len[req.ch] + 1'b1;
      if (exceed_len[req.ch] == 2'd1) begin
        res.state = ALARM_FIRST;
      end else begin
        res.state   = ALARM_SUSTAINED;
        event_count = event_count + 1'b1;
      end
    end else begin
      res.state = (exceed_len[req.ch] == 2'd2) ? ALARM_RECOVERED : ALARM_NORMAL;
      exceed_len[req.ch] = '0;
    end
    res.ch     = req.ch;
    res.avg    = SAMPLE_BITS'(win_sum[req.ch] / SUM_W'(WINDOW));
    res.events = event_count;
    return res;
  endfunction

  task automatic write_limit(input limit_reg_e idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ch_limit[idx] = val;
  endtask

  task automatic push_sample(input int ch, input int smp);
    sample_req_t req;
    req.ch  = CH_W'(ch);
    req.smp = SAMPLE_BITS'(smp);
    sample_queue.push_back(req);
  endtask

  // sampled mid-cycle so that queue, request and expectations are settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (sample_queue.size() != 0 || s_axis_tvalid || avg_expected.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // runs of one channel pushed above or below its limit, mixed with noise
  task automatic queue_random_phase(input int count);
    int n;
    int seg_left;
    int seg_ch;
    int bias;
    int v;
    n = 0;
    seg_left = 0;
    seg_ch = 0;
    bias = 1;
    while (n < count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(3, 14);
        seg_ch   = $urandom_range(0, NUM_CHANNELS - 1);
        bias     = ($urandom_range(0, 1) == 1) ? 1 : -1;
      end
      if ($urandom_range(0, 9) < 7) begin
        v = int'(ch_limit[seg_ch]) + bias * int'($urandom_range(0, 2000));
        if ($urandom_range(0, 7) == 0)
          v = int'(ch_limit[seg_ch]) - bias * int'($urandom_range(0, 2000));
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        push_sample(seg_ch, v);
        seg_left--;
      end else begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = 65535;
          default: v = $urandom_range(0, 65535);
        endcase
        push_sample($urandom_range(0, NUM_CHANNELS - 1), v);
      end
      n++;
    end
  endtask

  task automatic pick_limits();
    int r;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      r = $urandom_range(0, 7);
      case (r)
        0: write_limit(limit_reg_e'(c), '0);
        1: write_limit(limit_reg_e'(c), '1);
        2: write_limit(limit_reg_e'(c), LIMIT_W'($urandom_range(0, 65535)));
        default: write_limit(limit_reg_e'(c), LIMIT_W'($urandom_range(500, 40000)));
      endcase
    end
  endtask

  initial begin
    clear_filter();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: first samples fill the window, max sample sits at threshold
    push_sample(0, 0);
    push_sample(1, 65535);
    push_sample(2, 12345);
    push_sample(3, 1);
    wait_drained();

    write_limit(REG_LIMIT_CH0, '0);
    write_limit(REG_LIMIT_CH1, 16'd65534);
    write_limit(REG_LIMIT_CH2, 16'd1000);
    write_limit(REG_LIMIT_CH3, '1);
    // zero limit on channel 0: first, sustained, zeros in window, recovery
    push_sample(0, 1);
    push_sample(0, 0);
    push_sample(0, 0);
    push_sample(0, 0);
    push_sample(0, 0);
    push_sample(0, 0);
    push_sample(0, 0);
    push_sample(1, 65535);
    push_sample(1, 65535);
    push_sample(1, 0);
    push_sample(2, 0);
    push_sample(2, 0);
    push_sample(2, 0);
    push_sample(2, 0);
    push_sample(2, 0);
    push_sample(2, 0);
    push_sample(3, 65535);
    push_sample(3, 0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      pick_limits();
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // sender: bursts of requests separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (sample_queue.size() != 0) begin
        drv_req = sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_req.ch;
        s_axis_tdata  <= drv_req.smp;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall mode changes at random intervals
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
      mode_left     <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        mon_req.ch  = s_axis_tuser;
        mon_req.smp = s_axis_tdata[SAMPLE_BITS-1:0];
        avg_expected.push_back(filter_sample(mon_req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        // tdata: average, alarm_state, sustained_events
        got_res.ch     = m_axis_tuser;
        got_res.avg    = m_axis_tdata[15:0];
        got_res.state  = alarm_e'(m_axis_tdata[17:16]);
        got_res.events = m_axis_tdata[49:18];
        if (avg_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ch=%0d avg=%0d state=%0d events=%0d",
                   $time, got_res.ch, got_res.avg, got_res.state, got_res.events);
        end else begin
          exp_res = avg_expected.pop_front();
          if (got_res !== exp_res) begin
            errors++;
            $display("%0t: expected ch=%0d avg=%0d state=%0d events=%0d, %s%0d %0d %0d %0d",
                     $time, exp_res.ch, exp_res.avg, exp_res.state, exp_res.events,
                     "actual ", got_res.ch, got_res.avg, got_res.state,
                     got_res.events);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/mata_pkg.sv
hw/rtl/moving_average_threshold_alarm_top.sv
hw/rtl/mata_checker.sv
tb/testbench.sv
